### hw/rtl/lcs_pkg.sv
package lcs_pkg;

	typedef struct packed {
		logic       operation;
		logic [9:0] led_index;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [31:0] now_ms;
		logic       last;
	} lcs_in_t;

	typedef struct packed {
		logic [9:0] led_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} lcs_out_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [2:0] REG_SETTLE  = 3'd0;
	localparam logic [2:0] REG_MODE    = 3'd1;
	localparam logic [2:0] REG_CONT    = 3'd2;
	localparam logic [2:0] REG_THRESH  = 3'd3;
	localparam logic [2:0] REG_STEP    = 3'd4;
	localparam logic [2:0] REG_TIMEOUT = 3'd5;
	localparam logic [2:0] REG_PAUSE   = 3'd6;
	localparam logic [2:0] REG_COUNT   = 3'd7;

	localparam logic [15:0] K_FLOOR   = 16'd7;
	localparam logic [7:0]  BAND_LOW  = 8'd16;
	localparam logic [7:0]  BAND_MID  = 8'd32;
	localparam logic [7:0]  BAND_HIGH = 8'd60;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DIV,
		ST_MOVE,
		ST_WRITE,
		ST_EMIT
	} lcs_state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} lcs_div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [16:0] quo;
	} lcs_div_rsp_t;

	typedef logic [15:0] lcs_tab_t [256];

	// r = floor(r*v/65536) applied n times, starting from 1.0
	function automatic logic [16:0] pw16(input logic [16:0] v, input int n);
		logic [33:0] r;
		r = 34'd65536;
		for (int i = 0; i < n; i++)
			r = (r * {17'd0, v}) >> 16;
		return r[16:0];
	endfunction

	function automatic logic [15:0] frac_pow(input logic [16:0] x, input int p, input int q);
		logic [16:0] tgt;
		logic [16:0] y;
		logic [16:0] c;
		tgt = pw16(x, p);
		y = '0;
		for (int b = 15; b >= 0; b--) begin
			c = y | (17'd1 << b);
			if (pw16(c, q) <= tgt)
				y = c;
		end
		return y[15:0];
	endfunction

	// constant table of x^(p/q) sampled at the middle of each of 256 bins
	function automatic lcs_tab_t exp_table(input int p, input int q);
		lcs_tab_t r;
		for (int i = 0; i < 256; i++)
			r[i] = frac_pow(17'(256 * i + 128), p, q);
		return r;
	endfunction

endpackage

### hw/rtl/lcs_divider.sv
module lcs_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcs_pkg::lcs_div_req_t req,
	output lcs_pkg::lcs_div_rsp_t rsp
);
	import lcs_pkg::*;

	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [16:0] quo_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], 1'b0} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division of num*65536 by den, num < den, 16 quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!trial[32] || rem_q[31]) begin
				rem_q <= {1'b0, trial[31:0]};
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], 1'b0};
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### hw/rtl/led_color_smoothing_unit.sv
// Steps: a load or a settled tick is read, evaluated and written back; a moving tick
// also waits on the restoring divider, skipped when k sits at its floor, then moves.
// Throughput: one word at a time; the next input is taken once the word has been
// written back and any result has moved into the output register.
// Colour and hold memories are read through registers. Reset sets the configuration
// and control state; datapath registers and LED memories are undefined until written.
module led_color_smoothing_unit #(
	parameter int MAX_LEDS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lcs_pkg::lcs_in_t      in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lcs_pkg::lcs_out_t     out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import lcs_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	// band 0: exponent 0.9, band 1: 0.75, band 2: 0.6
	localparam lcs_tab_t EXP_09 = exp_table(9, 10);
	localparam lcs_tab_t EXP_075 = exp_table(3, 4);
	localparam lcs_tab_t EXP_06 = exp_table(3, 5);

	logic [15:0] settle_q;
	logic        mode_q, cont_q, pause_q;
	logic [7:0]  thresh_q, fstep_q;
	logic [15:0] timeout_q;
	logic [10:0] count_q;

	logic [31:0] goal_time_q, step_time_q;
	logic        flush_q, seeded_q;

	logic [47:0] colour_mem [MAX_LEDS];
	logic [31:0] hold_mem  [MAX_LEDS];
	logic [23:0] shown_rd, goal_rd;
	logic [31:0] hold_rd;

	lcs_state_t  state_q, state_d;
	lcs_in_t     item_q;
	lcs_out_t    out_q;
	logic        out_v_q;

	logic [23:0] new_shown_q, new_goal_q;
	logic [31:0] new_hold_q;
	logic        emit_q;
	logic [15:0] k_q;

	lcs_div_req_t div_req;
	lcs_div_rsp_t div_rsp;

	logic [2:0]  reg_idx;
	logic        wr_en;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q  <= 16'd200;
			mode_q    <= 1'b0;
			cont_q    <= 1'b0;
			thresh_q  <= '0;
			fstep_q   <= '0;
			timeout_q <= '0;
			pause_q   <= 1'b0;
			count_q   <= 11'd1;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				REG_SETTLE:  settle_q  <= pwdata[15:0];
				REG_MODE:    mode_q    <= pwdata[0];
				REG_CONT:    cont_q    <= pwdata[0];
				REG_THRESH:  thresh_q  <= pwdata[7:0];
				REG_STEP:    fstep_q   <= pwdata[7:0];
				REG_TIMEOUT: timeout_q <= pwdata[15:0];
				REG_PAUSE:   pause_q   <= pwdata[0];
				REG_COUNT:   count_q   <= pwdata[10:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SETTLE:  prdata = {16'd0, settle_q};
			REG_MODE:    prdata = {31'd0, mode_q};
			REG_CONT:    prdata = {31'd0, cont_q};
			REG_THRESH:  prdata = {24'd0, thresh_q};
			REG_STEP:    prdata = {24'd0, fstep_q};
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
			REG_PAUSE:   prdata = {31'd0, pause_q};
			REG_COUNT:   prdata = {21'd0, count_q};
			default:     prdata = '0;
		endcase
	end

	logic            in_fire, idx_ok;
	logic [AW-1:0]   addr;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign idx_ok   = ({1'b0, in_data.led_index} < count_q) &&
		({22'd0, in_data.led_index} < 32'(MAX_LEDS));
	assign addr     = AW'(item_q.led_index);

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			{shown_rd, goal_rd} <= colour_mem[addr];
			hold_rd  <= hold_mem[addr];
		end
		if (state_q == ST_WRITE) begin
			colour_mem[addr] <= {new_shown_q, new_goal_q};
			hold_mem[addr]   <= new_hold_q;
		end
	end

	// evaluation of the read entry
	logic [31:0] now;
	logic [23:0] rgb_in;
	logic [23:0] oc;
	logic [31:0] delta, span, elapsed;
	logic        settled;
	logic [7:0]  mn, mx, sel, a, b, dd;
	logic [8:0]  avg;
	logic        flick_en, flick;
	assign now    = item_q.now_ms;
	assign rgb_in = {item_q.red_in, item_q.green_in, item_q.blue_in};
	assign oc     = seeded_q ? shown_rd : rgb_in;
	assign delta  = goal_time_q - now;
	assign span   = goal_time_q - step_time_q;
	assign settled = (delta == 0) || delta[31] || (span == 0) || span[31];
	assign elapsed = now - (seeded_q ? hold_rd : now);
	assign flick_en = (thresh_q != 0) && (fstep_q != 0);

	always_comb begin
		mn = 8'hFF;
		mx = 8'h00;
		sel = 8'h00;
		for (int s = 0; s < 3; s++) begin
			a = rgb_in[s*8 +: 8];
			b = oc[s*8 +: 8];
			dd = (a > b) ? a - b : b - a;
			if (a < mn) mn = a;
			if (a > mx) mx = a;
			if (dd > sel) sel = dd;
		end
		avg = ({1'b0, mn} + {1'b0, mx}) >> 1;
		flick = flick_en && (avg < {1'b0, thresh_q}) &&
			(sel < fstep_q) && (rgb_in != 0) && (oc != 0);
	end

	function automatic logic [7:0] move_ch(input logic [7:0] c, input logic [7:0] g,
		input logic [15:0] k, input logic m);
		logic [7:0]  d;
		logic [15:0] kk, t;
		logic [24:0] pr;
		logic [8:0]  sv;
		d  = (g > c) ? g - c : c - g;
		kk = k;
		t  = k;
		if (d < BAND_LOW) t = EXP_06[k[15:8]];
		else if (d < BAND_MID) t = EXP_075[k[15:8]];
		else if (d < BAND_HIGH) t = EXP_09[k[15:8]];
		if (m && t > kk) kk = t;
		pr = {9'd0, kk} * {17'd0, d} + 25'd65535;
		sv = pr[24:16];
		return (g > c) ? c + sv[7:0] : c - sv[7:0];
	endfunction

	assign div_req.start = (state_q == ST_EVAL) && item_q.operation == OP_TICK &&
		!settled && (delta < span);
	assign div_req.num   = span - delta;
	assign div_req.den   = span;

	lcs_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && idx_ok) state_d = ST_READ;
			ST_READ:  state_d = ST_EVAL;
			ST_EVAL: begin
				if (item_q.operation == OP_LOAD || settled) state_d = ST_WRITE;
				else if (div_req.start) state_d = ST_DIV;
				else state_d = ST_MOVE;
			end
			ST_DIV:   if (div_rsp.done) state_d = ST_MOVE;
			ST_MOVE:  state_d = ST_WRITE;
			ST_WRITE: state_d = emit_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:  if (!out_v_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			goal_time_q <= '0;
			step_time_q <= '0;
			flush_q     <= 1'b0;
			seeded_q    <= 1'b0;
			out_v_q     <= 1'b0;
			emit_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && (!out_v_q || out_ready)) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			if (state_q == ST_EVAL) begin
				if (item_q.operation == OP_LOAD) begin
					emit_q      <= 1'b0;
					goal_time_q <= now + {16'd0, settle_q};
					if (!seeded_q) step_time_q <= now;
					if (item_q.last) seeded_q <= 1'b1;
				end else if (settled) begin
					emit_q <= flush_q && !pause_q;
					if (item_q.last) begin
						step_time_q <= now;
						flush_q     <= cont_q;
					end
				end else begin
					emit_q  <= !pause_q;
					flush_q <= 1'b1;
					if (item_q.last) step_time_q <= now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) item_q <= in_data;
		if (state_q == ST_EVAL) begin
			k_q <= K_FLOOR;
			if (item_q.operation == OP_LOAD) begin
				new_shown_q <= oc;
				if (flick && (timeout_q == 0 || elapsed[31] ||
					elapsed < {16'd0, timeout_q})) begin
					new_goal_q <= oc;
					new_hold_q <= seeded_q ? hold_rd : now;
				end else begin
					new_goal_q <= rgb_in;
					new_hold_q <= (flick_en || !seeded_q) ? now : hold_rd;
				end
			end else if (settled) begin
				new_shown_q <= goal_rd;
				new_goal_q  <= goal_rd;
				new_hold_q  <= now;
			end else begin
				new_goal_q <= goal_rd;
				new_hold_q <= hold_rd;
			end
		end
		if (state_q == ST_DIV && div_rsp.done)
			k_q <= (div_rsp.quo[16] || div_rsp.quo[15:0] < K_FLOOR) ?
				K_FLOOR : div_rsp.quo[15:0];
		if (state_q == ST_MOVE)
			new_shown_q <= {move_ch(shown_rd[23:16], goal_rd[23:16], k_q, mode_q),
				move_ch(shown_rd[15:8], goal_rd[15:8], k_q, mode_q),
				move_ch(shown_rd[7:0], goal_rd[7:0], k_q, mode_q)};
		if (state_q == ST_EMIT && (!out_v_q || out_ready)) begin
			out_q.led_out   <= item_q.led_index;
			out_q.red_out   <= new_shown_q[23:16];
			out_q.green_out <= new_shown_q[15:8];
			out_q.blue_out  <= new_shown_q[7:0];
			out_q.frame_end <= item_q.last;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV) else $error("divider finished outside wait");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && state_d == ST_IDLE |=> out_valid)
		else $error("result not presented");
`endif

endmodule

### tb/tb_led_color_smoothing_unit.sv
module tb_led_color_smoothing_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lcs_pkg::*;

	typedef enum int {ROW_WORD, ROW_REG} row_kind_t;
	typedef enum int {CHK_MODEL, CHK_NONE, CHK_FIXED} row_chk_t;

	typedef struct {
		row_kind_t  kind;
		logic [2:0] addr;
		logic [31:0] value;
		lcs_in_t    word;
		row_chk_t   chk;
		lcs_out_t   fixed;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	lcs_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	lcs_out_t    out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	led_color_smoothing_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [15:0] cfg_settle;
	logic        cfg_mode;
	logic        cfg_cont;
	logic [7:0]  cfg_thresh;
	logic [7:0]  cfg_step;
	logic [15:0] cfg_timeout;
	logic        cfg_pause;
	logic [10:0] cfg_count;

	logic [23:0] shown_rgb [1024];
	logic [23:0] goal_rgb [1024];
	logic [31:0] hold_ms [1024];
	bit          shown_known [1024];
	bit          goal_known [1024];
	logic [31:0] goal_ms;
	logic [31:0] step_ms;
	bit          flush_due;
	bit          seeded;
	logic [15:0] curve [3][256];

	lcs_out_t    pending_pixels [$];
	row_t        directed [$];
	int          mismatches;
	int          stall_left;
	bit          no_gaps;
	logic [31:0] clock_ms;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [63:0] q16_power(input logic [63:0] v, input int n);
		logic [63:0] acc;
		acc = 64'd65536;
		for (int j = 0; j < n; j++)
			acc = (acc * v) >> 16;
		return acc;
	endfunction

	function automatic logic [15:0] q16_root(input logic [63:0] x, input int p, input int q);
		logic [63:0] goal;
		logic [63:0] y;
		logic [63:0] c;
		goal = q16_power(x, p);
		y = 0;
		for (int b = 15; b >= 0; b--) begin
			c = y | (64'd1 << b);
			if (q16_power(c, q) <= goal)
				y = c;
		end
		return y[15:0];
	endfunction

	function automatic bit wrapped_nonpos(input logic [31:0] d);
		return d == 0 || d[31];
	endfunction

	function automatic bit tick_settles(input logic [31:0] now);
		return wrapped_nonpos(goal_ms - now) || wrapped_nonpos(goal_ms - step_ms);
	endfunction

	function automatic logic [7:0] ease_channel(input logic [7:0] cur, input logic [7:0] tgt,
			input logic [31:0] k);
		logic [31:0] d;
		logic [31:0] kk;
		logic [31:0] t;
		logic [31:0] mv;
		if (cur == tgt)
			return cur;
		d = (tgt > cur) ? tgt - cur : cur - tgt;
		kk = k;
		if (cfg_mode) begin
			t = k;
			if (d < BAND_LOW)
				t = curve[2][k[15:8]];
			else if (d < BAND_MID)
				t = curve[1][k[15:8]];
			else if (d < BAND_HIGH)
				t = curve[0][k[15:8]];
			if (t > kk)
				kk = t;
		end
		mv = (kk * d + 32'd65535) >> 16;
		return (tgt > cur) ? cur + mv[7:0] : cur - mv[7:0];
	endfunction

	function automatic void flicker_hold(input int i, input logic [31:0] now);
		logic [7:0]  a;
		logic [7:0]  b;
		logic [8:0]  mn;
		logic [8:0]  mx;
		logic [7:0]  sel;
		logic [7:0]  d;
		logic [31:0] el;
		mn = 255;
		mx = 0;
		sel = 0;
		for (int s = 0; s < 24; s += 8) begin
			a = goal_rgb[i][s +: 8];
			b = shown_rgb[i][s +: 8];
			d = (a > b) ? a - b : b - a;
			if (a < mn) mn = a;
			if (a > mx) mx = a;
			if (d > sel) sel = d;
		end
		if ((mn + mx) / 2 < cfg_thresh && sel < cfg_step && goal_rgb[i] != 0
				&& shown_rgb[i] != 0) begin
			el = now - hold_ms[i];
			if (cfg_timeout == 0 || el[31] || el < cfg_timeout)
				goal_rgb[i] = shown_rgb[i];
			else
				hold_ms[i] = now;
		end else begin
			hold_ms[i] = now;
		end
	endfunction

	function automatic bit smooth_pixel(input lcs_in_t w, output lcs_out_t r);
		int          i;
		logic [31:0] dlt;
		logic [31:0] spn;
		logic [63:0] k;
		logic [23:0] c;
		logic [23:0] g;
		bit          emit;
		r = '0;
		i = w.led_index;
		if (i >= cfg_count)
			return 0;
		if (w.operation == OP_LOAD) begin
			goal_ms = w.now_ms + cfg_settle;
			goal_rgb[i] = {w.red_in, w.green_in, w.blue_in};
			goal_known[i] = 1;
			if (!seeded) begin
				step_ms = w.now_ms;
				shown_rgb[i] = {w.red_in, w.green_in, w.blue_in};
				hold_ms[i] = w.now_ms;
				shown_known[i] = 1;
			end
			if (cfg_thresh > 0 && cfg_step > 0)
				flicker_hold(i, w.now_ms);
			if (w.last)
				seeded = 1;
			return 0;
		end
		dlt = goal_ms - w.now_ms;
		spn = goal_ms - step_ms;
		if (tick_settles(w.now_ms)) begin
			shown_rgb[i] = goal_rgb[i];
			hold_ms[i] = w.now_ms;
			shown_known[i] = 1;
			emit = flush_due;
			if (w.last) begin
				step_ms = w.now_ms;
				flush_due = cfg_cont;
			end
		end else begin
			if (dlt >= spn)
				k = K_FLOOR;
			else
				k = ({32'd0, spn - dlt} << 16) / {32'd0, spn};
			if (k < K_FLOOR)
				k = K_FLOOR;
			flush_due = 1;
			c = shown_rgb[i];
			g = goal_rgb[i];
			shown_rgb[i] = {ease_channel(c[23:16], g[23:16], k[31:0]),
				ease_channel(c[15:8], g[15:8], k[31:0]),
				ease_channel(c[7:0], g[7:0], k[31:0])};
			emit = 1;
			if (w.last)
				step_ms = w.now_ms;
		end
		if (!emit || cfg_pause)
			return 0;
		r.led_out = w.led_index;
		r.red_out = shown_rgb[i][23:16];
		r.green_out = shown_rgb[i][15:8];
		r.blue_out = shown_rgb[i][7:0];
		r.frame_end = w.last;
		return 1;
	endfunction

	// keep clear of memory entries that were never written
	function automatic bit word_allowed(input lcs_in_t w);
		int i;
		i = w.led_index;
		if (i >= cfg_count)
			return 1;
		if (w.operation == OP_LOAD)
			return !(seeded && cfg_thresh > 0 && cfg_step > 0) || shown_known[i];
		if (!goal_known[i])
			return 0;
		return tick_settles(w.now_ms) || shown_known[i];
	endfunction

	function automatic lcs_in_t mk_word(input logic op, input logic [9:0] idx,
			input logic [23:0] rgb, input logic [31:0] now, input logic last);
		lcs_in_t w;
		w.operation = op;
		w.led_index = idx;
		{w.red_in, w.green_in, w.blue_in} = rgb;
		w.now_ms = now;
		w.last = last;
		return w;
	endfunction

	function automatic void add_word(input lcs_in_t w, input row_chk_t chk, input lcs_out_t fx);
		row_t r;
		r.kind = ROW_WORD;
		r.addr = '0;
		r.value = '0;
		r.word = w;
		r.chk = chk;
		r.fixed = fx;
		directed.push_back(r);
	endfunction

	function automatic void add_reg(input logic [2:0] a, input logic [31:0] v);
		row_t r;
		r.kind = ROW_REG;
		r.addr = a;
		r.value = v;
		r.word = '0;
		r.chk = CHK_NONE;
		r.fixed = '0;
		directed.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input lcs_in_t w, input row_chk_t chk, input lcs_out_t fx);
		int       gap;
		lcs_out_t r;
		bit       has;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		has = smooth_pixel(w, r);
		if (chk == CHK_FIXED)
			pending_pixels.push_back(fx);
		else if (chk == CHK_MODEL && has)
			pending_pixels.push_back(r);
	endtask

	task automatic send_checked(input lcs_in_t w);
		if (word_allowed(w))
			send_word(w, CHK_MODEL, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] a, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {a, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (a)
			REG_SETTLE:  cfg_settle = v[15:0];
			REG_MODE:    cfg_mode = v[0];
			REG_CONT:    cfg_cont = v[0];
			REG_THRESH:  cfg_thresh = v[7:0];
			REG_STEP:    cfg_step = v[7:0];
			REG_TIMEOUT: cfg_timeout = v[15:0];
			REG_PAUSE:   cfg_pause = v[0];
			REG_COUNT:   cfg_count = v[10:0];
			default: ;
		endcase
	endtask

	task automatic random_config();
		int r;
		r = $urandom_range(0, 9);
		reg_write(REG_SETTLE, r < 2 ? 0 : r < 3 ? 65535 : r < 8 ? $urandom_range(1, 60)
			: $urandom_range(0, 65535));
		reg_write(REG_MODE, $urandom_range(0, 1));
		reg_write(REG_CONT, $urandom_range(0, 1));
		reg_write(REG_THRESH, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
		reg_write(REG_STEP, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
		r = $urandom_range(0, 3);
		reg_write(REG_TIMEOUT, r == 0 ? 0 : r == 1 ? $urandom_range(1, 50)
			: $urandom_range(0, 65535));
		reg_write(REG_PAUSE, $urandom_range(0, 7) == 0);
		r = $urandom_range(0, 9);
		reg_write(REG_COUNT, r == 0 ? 1024 : r == 1 ? $urandom_range(1, 1024)
			: $urandom_range(1, 16));
	endtask

	function automatic logic [9:0] pick_led(input int n);
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return $urandom_range(0, n - 1);
		if (r < 9 || cfg_count >= 1024)
			return $urandom_range(0, 1023);
		return $urandom_range(cfg_count, 1023);
	endfunction

	task automatic random_phase(input int words);
		int          sent;
		int          n;
		int          frames;
		logic [23:0] rgb;
		logic [31:0] adv;
		lcs_in_t     w;
		n = (cfg_count < 16) ? cfg_count : 16;
		sent = 0;
		while (sent < words) begin
			if ($urandom_range(0, 9) < 2) begin
				if ($urandom_range(0, 15) == 0)
					clock_ms = $urandom;
				else
					clock_ms += $urandom_range(0, 80);
				w = mk_word($urandom_range(0, 1), pick_led(n), $urandom, clock_ms,
					$urandom_range(0, 1));
				send_checked(w);
				sent++;
			end else begin
				for (int i = 0; i < n; i++) begin
					rgb = $urandom;
					if ($urandom_range(0, 2) == 0)
						rgb = rgb & 24'h0F0F0F;
					send_checked(mk_word(OP_LOAD, i, rgb, clock_ms, i == n - 1));
				end
				sent += n;
				frames = $urandom_range(2, 8);
				adv = cfg_settle / $urandom_range(2, 6) + $urandom_range(1, 5);
				for (int f = 0; f < frames; f++) begin
					clock_ms += adv;
					for (int i = 0; i < n; i++)
						send_checked(mk_word(OP_TICK, i, $urandom, clock_ms, i == n - 1));
					sent += n;
				end
			end
		end
	endtask

	task automatic report(input string what, input lcs_out_t e, input lcs_out_t a);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected led %0d rgb %h %h %h end %b, got led %0d rgb %h %h %h end %b",
				what, e.led_out, e.red_out, e.green_out, e.blue_out, e.frame_end,
				a.led_out, a.red_out, a.green_out, a.blue_out, a.frame_end);
	endtask

	always @(posedge clk) begin
		lcs_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report("unexpected word", '0, out_data);
			end else begin
				e = pending_pixels.pop_front();
				if (e.led_out !== out_data.led_out || e.red_out !== out_data.red_out
						|| e.green_out !== out_data.green_out
						|| e.blue_out !== out_data.blue_out
						|| e.frame_end !== out_data.frame_end)
					report("mismatch", e, out_data);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		lcs_out_t fx;
		int       waited;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		stall_left = 0;
		no_gaps = 0;
		cfg_settle = 200;
		cfg_mode = 0;
		cfg_cont = 0;
		cfg_thresh = 0;
		cfg_step = 0;
		cfg_timeout = 0;
		cfg_pause = 0;
		cfg_count = 1;
		goal_ms = 0;
		step_ms = 0;
		flush_due = 0;
		seeded = 0;
		for (int i = 0; i < 1024; i++) begin
			shown_rgb[i] = 0;
			goal_rgb[i] = 0;
			hold_ms[i] = 0;
			shown_known[i] = 0;
			goal_known[i] = 0;
		end
		for (int i = 0; i < 256; i++) begin
			curve[0][i] = q16_root(256 * i + 128, 9, 10);
			curve[1][i] = q16_root(256 * i + 128, 3, 4);
			curve[2][i] = q16_root(256 * i + 128, 3, 5);
		end

		add_word(mk_word(OP_LOAD, 0, 24'h000000, 1000, 1), CHK_NONE, '0);
		fx = '{led_out: 0, red_out: 0, green_out: 0, blue_out: 0, frame_end: 1};
		add_word(mk_word(OP_TICK, 0, 24'h000000, 1000, 1), CHK_FIXED, fx);
		add_word(mk_word(OP_LOAD, 0, 24'hFFFFFF, 1000, 1), CHK_NONE, '0);
		fx = '{led_out: 0, red_out: 8'hFF, green_out: 8'hFF, blue_out: 8'hFF, frame_end: 1};
		add_word(mk_word(OP_TICK, 0, 24'h000000, 1300, 1), CHK_FIXED, fx);
		add_word(mk_word(OP_TICK, 0, 24'hFFFFFF, 1400, 1), CHK_NONE, '0);
		add_word(mk_word(OP_LOAD, 5, 24'h123456, 1450, 1), CHK_NONE, '0);
		add_reg(REG_COUNT, 1024);
		add_word(mk_word(OP_LOAD, 1023, 24'hFF0000, 1500, 1), CHK_NONE, '0);
		add_word(mk_word(OP_TICK, 1023, 24'h000000, 1800, 0), CHK_MODEL, '0);
		add_reg(REG_MODE, 1);
		add_reg(REG_SETTLE, 65535);
		add_word(mk_word(OP_LOAD, 0, 24'h801005, 2000, 1), CHK_NONE, '0);
		add_word(mk_word(OP_TICK, 0, 24'h000000, 2100, 1), CHK_MODEL, '0);
		add_word(mk_word(OP_TICK, 0, 24'h000000, 30000, 1), CHK_MODEL, '0);
		add_word(mk_word(OP_TICK, 0, 24'h000000, 70000, 1), CHK_MODEL, '0);
		add_reg(REG_THRESH, 255);
		add_reg(REG_STEP, 255);
		add_reg(REG_TIMEOUT, 0);
		add_word(mk_word(OP_LOAD, 0, 24'h7F1106, 70010, 1), CHK_NONE, '0);
		add_word(mk_word(OP_TICK, 0, 24'h000000, 70020, 1), CHK_MODEL, '0);
		add_reg(REG_TIMEOUT, 65535);
		add_reg(REG_CONT, 1);
		add_reg(REG_PAUSE, 1);
		add_word(mk_word(OP_TICK, 0, 24'h000000, 80000, 1), CHK_NONE, '0);
		add_reg(REG_PAUSE, 0);
		add_reg(REG_SETTLE, 0);
		add_word(mk_word(OP_LOAD, 0, 24'h000000, 32'hFFFFFFF0, 1), CHK_NONE, '0);
		add_word(mk_word(OP_TICK, 0, 24'h000000, 32'h00000010, 1), CHK_MODEL, '0);
		add_word(mk_word(OP_TICK, 0, 24'h000000, 32'h00000020, 1), CHK_MODEL, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[j]) begin
			if (directed[j].kind == ROW_REG) begin
				drain();
				reg_write(directed[j].addr, directed[j].value);
			end else begin
				send_word(directed[j].word, directed[j].chk, directed[j].fixed);
			end
		end

		clock_ms = 100;
		for (int p = 0; p < 10; p++) begin
			drain();
			random_config();
			no_gaps = ($urandom_range(0, 3) == 0);
			random_phase(80);
		end

		in_valid <= 1'b0;
		waited = 0;
		while (pending_pixels.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
